@@ src/sstok_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Shader source tokenizer package
// Shared constants, token classes and the command record that the front end
// hands to the back end.
// ----------------------------------------------------------------------------
package sstok_pkg;

  localparam int unsigned PendingMax = 14;
  localparam int unsigned PendingCap = 14;
  localparam int unsigned PendLimit  = (PendingMax < PendingCap) ? PendingMax : PendingCap;
  localparam int unsigned PendW      = 4;
  localparam int unsigned QueueDepth = 4;

  localparam logic [2:0] ClsWs      = 3'd0;
  localparam logic [2:0] ClsComment = 3'd1;
  localparam logic [2:0] ClsNumber  = 3'd2;
  localparam logic [2:0] ClsWord    = 3'd3;
  localparam logic [2:0] ClsOther   = 3'd4;

  localparam logic [7:0] ChBackslash  = 8'h5C;
  localparam logic [7:0] ChLf         = 8'h0A;
  localparam logic [7:0] ChUnderscore = 8'h5F;
  localparam logic [7:0] ChDot        = 8'h2E;

  typedef struct packed {
    logic       vld;
    logic [7:0] chr;
    logic [2:0] cls;
    logic       tstart;
    logic       tend;
  } slot_t;

  // Emission order is slot a, slot b, the newline run, then slot c.
  typedef struct packed {
    slot_t            a;
    slot_t            b;
    logic [PendW-1:0] nl_cnt;
    logic             nl_start;
    logic             nl_end;
    slot_t            c;
    logic             last;
  } cmd_t;

endpackage
`default_nettype wire

@@ src/sstok_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Shader source tokenizer channels
// Valid/ready channels for source characters and for tagged characters.
// ----------------------------------------------------------------------------
interface sstok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_input;

  modport source (output valid, output char_in, output end_of_input, input ready);
  modport sink (input valid, input char_in, input end_of_input, output ready);
endinterface

interface sstok_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic [2:0] token_class;
  logic       token_start;
  logic       token_end;
  logic       stream_last;

  modport source (output valid, output char_out, output token_class, output token_start,
                  output token_end, output stream_last, input ready);
  modport sink (input valid, input char_out, input token_class, input token_start,
                input token_end, input stream_last, output ready);
endinterface
`default_nettype wire

@@ src/shader_source_char_tokenizer_core.sv @@
`default_nettype none
// Path: a character's result is released when the next character (or the end-of-input
// character itself) is accepted, then moves through the queue to the output register.
// Throughput: one character per cycle while each character releases at most one
// result and the output is not stalled; one with more results emits them in turn, and
// the command queue of QUEUE_DEPTH entries lets input continue until it fills.
// Reset: asynchronous, clears scanner state, queue and output; no clearing pass.
// ----------------------------------------------------------------------------
// Shader source tokenizer core
// Tags each source character with a token class and start and end marks.
// ----------------------------------------------------------------------------
module shader_source_char_tokenizer_core #(
  parameter int unsigned QUEUE_DEPTH = sstok_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sstok_in_if.sink     in_ch_i,
  sstok_out_if.source  out_ch_o
);
  import sstok_pkg::*;

  logic q_push, q_full, q_pop, q_head_vld;
  cmd_t q_push_cmd, q_head;

  sstok_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch_i   (in_ch_i),
    .q_ready_i (!q_full),
    .push_o    (q_push),
    .cmd_o     (q_push_cmd)
  );

  sstok_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_vld_o (q_head_vld),
    .head_o     (q_head)
  );

  sstok_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_vld_i (q_head_vld),
    .head_i     (q_head),
    .pop_o      (q_pop),
    .out_ch_o   (out_ch_o)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("Command pushed into a full queue.");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_head_vld) else $error("Command popped from an empty queue.");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch_o.valid && out_ch_o.stream_last) |-> out_ch_o.token_end)
    else $error("Final result of the stream does not end its token.");

  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch_o.valid |-> (out_ch_o.token_class <= ClsOther))
    else $error("Token class out of range.");
`endif

endmodule
`default_nettype wire

@@ src/sstok_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Shader source tokenizer front end
// Accepts one character per transaction, runs the scanner state and turns
// each character into a command that lists the results it releases.
// ----------------------------------------------------------------------------
module sstok_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  sstok_in_if.sink          in_ch_i,
  input  logic              q_ready_i,
  output logic              push_o,
  output sstok_pkg::cmd_t   cmd_o
);
  import sstok_pkg::*;

  typedef enum logic [2:0] {
    ModeIdle, ModeWs, ModeLine, ModeBlock, ModeNumber, ModeWord, ModeOp
  } mode_e;

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_id(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || is_digit(c) ||
           c == ChUnderscore;
  endfunction

  function automatic logic op_pair(logic [7:0] a, logic [7:0] c);
    return (a == "+" && (c == "+" || c == "=")) || (a == "-" && (c == "-" || c == "=")) ||
           (a == "<" && (c == "<" || c == "=")) || (a == ">" && (c == ">" || c == "=")) ||
           (a == "=" && c == "=") || (a == "!" && c == "=") ||
           (a == "&" && (c == "&" || c == "=")) || (a == "|" && (c == "|" || c == "=")) ||
           (a == "^" && (c == "^" || c == "=")) || (a == "*" && c == "=") ||
           (a == "%" && c == "=") || (a == "/" && (c == "=" || c == "/" || c == "*"));
  endfunction

  mode_e            mode_q, mode_d;
  logic [7:0]       op_a_q, op_a_d, op_b_q, op_b_d;
  logic [1:0]       op_len_q, op_len_d;
  logic             star_q, star_d, bslash_q, bslash_d;
  logic [PendW-1:0] pend_q, pend_d;
  logic [7:0]       held_char_q, held_char_d;
  logic [2:0]       held_cls_q, held_cls_d;
  logic             held_start_q, held_start_d, held_vld_q, held_vld_d;

  logic       accept;
  logic [7:0] c;
  logic       cont, ext, to_comment, path_cont, path_new;
  logic [2:0] cls, k, held_cls_eff;
  slot_t      fl;
  cmd_t       cmd;

  assign c           = in_ch_i.char_in;
  assign in_ch_i.ready = q_ready_i;
  assign accept      = in_ch_i.valid && q_ready_i;

  always_comb begin
    mode_d       = mode_q;
    op_a_d       = op_a_q;
    op_b_d       = op_b_q;
    op_len_d     = op_len_q;
    star_d       = star_q;
    bslash_d     = bslash_q;
    pend_d       = pend_q;
    held_char_d  = held_char_q;
    held_cls_d   = held_cls_q;
    held_start_d = held_start_q;
    held_vld_d   = held_vld_q;
    cmd          = '0;
    cont         = 1'b0;
    ext          = 1'b0;
    to_comment   = 1'b0;
    path_cont    = 1'b0;
    path_new     = 1'b0;
    cls          = ClsOther;
    k            = ClsOther;
    held_cls_eff = held_cls_q;
    fl           = '0;

    if (bslash_q) begin
      bslash_d = 1'b0;
      if (c == ChLf && pend_q < PendW'(PendLimit)) begin
        pend_d = pend_q + 1'b1;
      end
    end else if (c == ChBackslash && mode_q != ModeLine && mode_q != ModeBlock) begin
      bslash_d = 1'b1;
    end else begin
      unique case (mode_q)
        ModeWs: begin
          cont = is_space(c);
          cls  = ClsWs;
        end
        ModeLine: begin
          cont = (c != ChLf);
          cls  = ClsComment;
        end
        ModeBlock: begin
          cont   = 1'b1;
          cls    = ClsComment;
          if (star_q && c == "/") begin
            mode_d = ModeIdle;
          end
          star_d = (c == "*");
        end
        ModeNumber: begin
          cont = is_id(c) || c == ChDot;
          cls  = ClsNumber;
        end
        ModeWord: begin
          cont = is_id(c);
          cls  = ClsWord;
        end
        ModeOp: begin
          if (op_len_q == 2'd1) begin
            ext = op_pair(op_a_q, c);
          end else if (op_len_q == 2'd2) begin
            ext = (op_a_q == "<" || op_a_q == ">") && op_b_q == op_a_q && c == "=";
          end
          cont = ext;
          cls  = ClsOther;
          to_comment = ext && op_len_q == 2'd1 && op_a_q == "/" && (c == "/" || c == "*");
          if (to_comment) begin
            mode_d       = (c == "/") ? ModeLine : ModeBlock;
            star_d       = 1'b0;
            cls          = ClsComment;
            held_cls_eff = ClsComment;
          end else if (ext && op_len_q == 2'd1) begin
            op_b_d   = c;
            op_len_d = 2'd2;
          end else if (ext) begin
            op_len_d = 2'd3;
          end
        end
        default: cont = 1'b0;
      endcase

      if (cont) begin
        path_cont    = 1'b1;
        cmd.a        = '{vld: held_vld_q, chr: held_char_q, cls: held_cls_eff,
                         tstart: held_start_q, tend: 1'b0};
        held_char_d  = c;
        held_cls_d   = cls;
        held_start_d = !held_vld_q;
        held_vld_d   = 1'b1;
      end else begin
        path_new = 1'b1;
        if (is_space(c)) begin
          k      = ClsWs;
          mode_d = ModeWs;
        end else if (is_digit(c)) begin
          k      = ClsNumber;
          mode_d = ModeNumber;
        end else if (is_id(c)) begin
          k      = ClsWord;
          mode_d = ModeWord;
        end else begin
          k        = ClsOther;
          mode_d   = ModeOp;
          op_a_d   = c;
          op_b_d   = 8'd0;
          op_len_d = 2'd1;
        end
        cmd.a        = '{vld: held_vld_q, chr: held_char_q, cls: held_cls_q,
                         tstart: held_start_q,
                         tend: !(held_cls_q == ClsWs && pend_q != '0)};
        cmd.nl_cnt   = pend_q;
        cmd.nl_start = !(held_vld_q && held_cls_q == ClsWs);
        cmd.nl_end   = (k != ClsWs);
        pend_d       = '0;
        held_char_d  = c;
        held_cls_d   = k;
        held_start_d = !(k == ClsWs && pend_q != '0);
        held_vld_d   = 1'b1;
      end
    end

    if (in_ch_i.end_of_input) begin
      cmd.last = 1'b1;
      fl = '{vld: held_vld_d, chr: held_char_d, cls: held_cls_d, tstart: held_start_d,
             tend: !(held_cls_d == ClsWs && pend_d != '0)};
      if (path_new) begin
        cmd.c = fl;
      end else begin
        if (path_cont) begin
          cmd.b = fl;
        end else begin
          cmd.a = fl;
        end
        cmd.nl_cnt   = pend_d;
        cmd.nl_start = !(held_vld_d && held_cls_d == ClsWs);
        cmd.nl_end   = 1'b1;
      end
      mode_d       = ModeIdle;
      op_a_d       = 8'd0;
      op_b_d       = 8'd0;
      op_len_d     = 2'd0;
      star_d       = 1'b0;
      bslash_d     = 1'b0;
      pend_d       = '0;
      held_char_d  = 8'd0;
      held_cls_d   = ClsWs;
      held_start_d = 1'b0;
      held_vld_d   = 1'b0;
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && (cmd.a.vld || cmd.b.vld || cmd.c.vld || cmd.nl_cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeIdle;
      op_a_q       <= 8'd0;
      op_b_q       <= 8'd0;
      op_len_q     <= 2'd0;
      star_q       <= 1'b0;
      bslash_q     <= 1'b0;
      pend_q       <= '0;
      held_char_q  <= 8'd0;
      held_cls_q   <= ClsWs;
      held_start_q <= 1'b0;
      held_vld_q   <= 1'b0;
    end else if (accept) begin
      mode_q       <= mode_d;
      op_a_q       <= op_a_d;
      op_b_q       <= op_b_d;
      op_len_q     <= op_len_d;
      star_q       <= star_d;
      bslash_q     <= bslash_d;
      pend_q       <= pend_d;
      held_char_q  <= held_char_d;
      held_cls_q   <= held_cls_d;
      held_start_q <= held_start_d;
      held_vld_q   <= held_vld_d;
    end
  end

endmodule
`default_nettype wire

@@ src/sstok_cmd_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Shader source tokenizer command queue
// Small first-in first-out buffer of commands between front and back end.
// ----------------------------------------------------------------------------
module sstok_cmd_queue #(
  parameter int unsigned DEPTH = sstok_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sstok_pkg::cmd_t push_cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_vld_o,
  output sstok_pkg::cmd_t head_o
);
  import sstok_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(DEPTH));
  assign head_vld_o = (cnt_q != '0);
  assign head_o     = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule
`default_nettype wire

@@ src/sstok_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Shader source tokenizer back end
// Walks the head command into the output register one result per unstalled cycle.
// ----------------------------------------------------------------------------
module sstok_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_vld_i,
  input  sstok_pkg::cmd_t head_i,
  output logic            pop_o,
  sstok_out_if.source     out_ch_o
);
  import sstok_pkg::*;

  logic [3:0]       done_q, done_d;
  logic [PendW-1:0] nl_idx_q, nl_idx_d;
  logic             out_vld_q, out_vld_d;
  logic [7:0]       out_char_q;
  logic [2:0]       out_cls_q;
  logic             out_start_q, out_end_q, out_last_q;

  logic [3:0] mask, rem, cur_done, rem_after;
  logic       advance, emit, sel_nl, nl_last, last_item;
  slot_t      cur;

  always_comb begin
    mask      = {head_i.c.vld, head_i.nl_cnt != '0, head_i.b.vld, head_i.a.vld};
    rem       = mask & ~done_q;
    advance   = !out_vld_q || out_ch_o.ready;
    emit      = head_vld_i && advance;
    nl_last   = (PendW'(nl_idx_q + 1'b1) == head_i.nl_cnt);
    sel_nl    = 1'b0;
    cur       = head_i.c;
    cur.tend  = 1'b1;
    cur_done  = 4'b1000;
    priority if (rem[0]) begin
      cur      = head_i.a;
      cur_done = 4'b0001;
    end else if (rem[1]) begin
      cur      = head_i.b;
      cur_done = 4'b0010;
    end else if (rem[2]) begin
      sel_nl   = 1'b1;
      cur      = '{vld: 1'b1, chr: ChLf, cls: ClsWs,
                   tstart: (nl_idx_q == '0) && head_i.nl_start,
                   tend: nl_last && head_i.nl_end};
      cur_done = nl_last ? 4'b0100 : 4'b0000;
    end else begin
      cur      = head_i.c;
      cur.tend = 1'b1;
      cur_done = 4'b1000;
    end
    rem_after = rem & ~cur_done;
    last_item = (rem_after == 4'b0000);

    done_d = done_q;
    nl_idx_d = nl_idx_q;
    pop_o  = 1'b0;
    if (emit) begin
      if (last_item) begin
        done_d   = 4'b0000;
        nl_idx_d = '0;
        pop_o    = 1'b1;
      end else begin
        done_d = done_q | cur_done;
        if (sel_nl) begin
          nl_idx_d = nl_idx_q + 1'b1;
        end
      end
    end
    out_vld_d = advance ? emit : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 4'b0000;
      nl_idx_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      done_q    <= done_d;
      nl_idx_q  <= nl_idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q  <= cur.chr;
      out_cls_q   <= cur.cls;
      out_start_q <= cur.tstart;
      out_end_q   <= cur.tend;
      out_last_q  <= last_item && head_i.last;
    end
  end

  assign out_ch_o.valid       = out_vld_q;
  assign out_ch_o.char_out    = out_char_q;
  assign out_ch_o.token_class = out_cls_q;
  assign out_ch_o.token_start = out_start_q;
  assign out_ch_o.token_end   = out_end_q;
  assign out_ch_o.stream_last = out_last_q;

endmodule
`default_nettype wire
